[rtl/max_heap_build_macros.svh]
// Assertion macros for the max-heap build block.
`ifndef MAX_HEAP_BUILD_MACROS_SVH
`define MAX_HEAP_BUILD_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MHB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mhb_pkg.sv]
// Shared constants and types for the max-heap build block.
package mhb_pkg;

   localparam int MAX_ELEMS = 64;
   localparam int ADDR_W    = 6;   // heap index width
   localparam int CNT_W     = 7;   // element count width, holds MAX_ELEMS itself
   localparam int CHILD_W   = 8;   // child index width, holds 2*63+2
   localparam int DATA_W    = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_NODE,
      ST_LEFT,
      ST_RIGHT,
      ST_CMP,
      ST_SWAP,
      ST_EMIT
   } state_type;

endpackage

[rtl/max_heap_build.sv]
// Binary max-heap builder: load a set, heapify it in place, stream the heap out.
//
// Values arrive one per transfer (start high while busy is low) and are
// written into a 64-entry synchronous store; busy stays low throughout
// loading. The transfer marked last ends the set: busy rises and the block
// heapifies the store bottom-up, sifting down every non-leaf position from
// floor(n/2)-1 back to the root. Each sift step goes through the single
// read port of the store: read node, read left child, read right child,
// compare (which also makes the first write of a swap), plus a swap state
// for the second write of a swap, and a sift ends with a check when the
// node has no children. The heap is then read out in index order, one
// result per cycle; rsp_strobe marks each result for exactly one cycle and
// the receiver cannot stall it, so it must take every strobed cycle. busy
// falls as the final result appears on the ports, so a new set may start
// while that result is still there. Elements beyond 64 are dropped;
// rsp_overflow is then high on every result of that set. Reset needs no
// clearing pass: only entries written for the current set are ever used.
`include "max_heap_build_macros.svh"

module max_heap_build
   import mhb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_element_value,
   input  logic                     req_last_element,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_heap_value,
   output logic [ADDR_W-1:0]        rsp_position,
   output logic                     rsp_last_result,
   output logic                     rsp_overflow
);

   // Element store: one write port, one registered read port.
   logic signed [DATA_W-1:0] store_mem [MAX_ELEMS];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   // Control state.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [ADDR_W-1:0]  root_ff, root_in;     // position whose sift is running
   logic [ADDR_W-1:0]  node_ff, node_in;     // current position of the sifted value
   logic [ADDR_W-1:0]  big_ff, big_in;       // child taking part in a swap
   logic [ADDR_W-1:0]  emit_ff, emit_in;     // next position to read out

   // Sift datapath registers.
   logic signed [DATA_W-1:0] node_val_ff, node_val_in;
   logic signed [DATA_W-1:0] left_val_ff, left_val_in;

   // Result stage, aligned with the read latency of the store.
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic               last_ff, last_in;
   logic               pend_ovf_ff, pend_ovf_in;

   // Derived values.
   logic               accept;
   logic               has_room;
   logic [CNT_W-1:0]   n_after;
   logic [CNT_W-1:0]   half_n;
   logic [CHILD_W-1:0] left_idx;
   logic [CHILD_W-1:0] right_idx;
   logic               left_ok;
   logic               right_ok;
   logic               pick_left;
   logic               pick_right;
   logic signed [DATA_W-1:0] win_val;
   logic               emit_last;

   assign accept    = start && !busy;
   assign has_room  = count_ff < CNT_W'(MAX_ELEMS);
   assign n_after   = has_room ? count_ff + CNT_W'(1) : count_ff;
   assign half_n    = n_after >> 1;
   assign left_idx  = {1'b0, node_ff, 1'b1};
   assign right_idx = left_idx + CHILD_W'(1);
   assign left_ok   = left_idx  < {1'b0, count_ff};
   assign right_ok  = right_idx < {1'b0, count_ff};
   // Left beats the node only when strictly larger; right beats the winner
   // only when strictly larger, so a tie between children keeps the left.
   assign pick_left  = left_val_ff > node_val_ff;
   assign win_val    = pick_left ? left_val_ff : node_val_ff;
   assign pick_right = right_ok && (rd_data_ff > win_val);
   assign emit_last  = ({1'b0, emit_ff} + CNT_W'(1)) == count_ff;

   // Store access.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_element) begin
               state_in = (half_n == '0) ? ST_EMIT : ST_NODE;
            end
         end
         ST_NODE: begin
            if (!left_ok) begin
               state_in = (root_ff == '0) ? ST_EMIT : ST_NODE;
            end else begin
               state_in = ST_LEFT;
            end
         end
         ST_LEFT:  state_in = ST_RIGHT;
         ST_RIGHT: state_in = ST_CMP;
         ST_CMP: begin
            if (pick_left || pick_right) begin
               state_in = ST_SWAP;
            end else begin
               state_in = (root_ff == '0) ? ST_EMIT : ST_NODE;
            end
         end
         ST_SWAP:  state_in = ST_NODE;
         ST_EMIT: begin
            if (emit_last) begin
               state_in = ST_LOAD;
            end
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   // Datapath and store control.
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      root_in     = root_ff;
      node_in     = node_ff;
      big_in      = big_ff;
      emit_in     = emit_ff;
      node_val_in = node_val_ff;
      left_val_in = left_val_ff;
      pend_in     = 1'b0;
      pos_in      = pos_ff;
      last_in     = last_ff;
      pend_ovf_in = pend_ovf_ff;
      rd_addr     = node_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = req_element_value;
      busy        = state_ff != ST_LOAD;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               // Append while there is room, else drop and flag.
               wr_en    = has_room;
               count_in = n_after;
               ovf_in   = ovf_ff || !has_room;
               emit_in  = '0;
               if (req_last_element) begin
                  root_in = ADDR_W'(half_n - CNT_W'(1));
                  node_in = ADDR_W'(half_n - CNT_W'(1));
               end
            end
         end
         ST_NODE: begin
            rd_addr = node_ff;
            if (!left_ok && root_ff != '0) begin
               root_in = root_ff - ADDR_W'(1);
               node_in = root_ff - ADDR_W'(1);
            end
         end
         ST_LEFT: begin
            rd_addr     = left_idx[ADDR_W-1:0];
            node_val_in = rd_data_ff;
         end
         ST_RIGHT: begin
            rd_addr     = right_idx[ADDR_W-1:0];
            left_val_in = rd_data_ff;
         end
         ST_CMP: begin
            if (pick_right) begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_data = rd_data_ff;
               big_in  = right_idx[ADDR_W-1:0];
            end else if (pick_left) begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_data = left_val_ff;
               big_in  = left_idx[ADDR_W-1:0];
            end else if (root_ff != '0) begin
               root_in = root_ff - ADDR_W'(1);
               node_in = root_ff - ADDR_W'(1);
            end
         end
         ST_SWAP: begin
            // Complete the swap and follow the value down.
            wr_en   = 1'b1;
            wr_addr = big_ff;
            wr_data = node_val_ff;
            node_in = big_ff;
         end
         ST_EMIT: begin
            rd_addr     = emit_ff;
            pend_in     = 1'b1;
            pos_in      = emit_ff;
            last_in     = emit_last;
            pend_ovf_in = ovf_ff;
            emit_in     = emit_ff + ADDR_W'(1);
            if (emit_last) begin
               // Start a fresh, empty set.
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            rd_addr = node_ff;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
      root_ff     <= root_in;
      node_ff     <= node_in;
      big_ff      <= big_in;
      emit_ff     <= emit_in;
      node_val_ff <= node_val_in;
      left_val_ff <= left_val_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      pend_ovf_ff <= pend_ovf_in;
   end

   assign rsp_strobe      = pend_ff;
   assign rsp_heap_value  = rd_data_ff;
   assign rsp_position    = pos_ff;
   assign rsp_last_result = last_ff;
   assign rsp_overflow    = pend_ovf_ff;

   // Results of one set come out on consecutive cycles at rising positions.
   `MHB_ASSERT_NEXT(a_emit_seq, rsp_strobe && !rsp_last_result, rsp_strobe && rsp_position == $past(rsp_position) + ADDR_W'(1), "heap read-out skipped or repeated a position")
   // A last transfer always starts a build.
   `MHB_ASSERT_NEXT(a_last_busy, start && !busy && req_last_element, busy, "last transfer did not start the build")
   // The count never exceeds the store depth.
   `MHB_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CNT_W'(MAX_ELEMS), "element count beyond capacity")
   // A swap writes only positions inside the set.
   `MHB_ASSERT_NOW(a_swap_range, state_ff == ST_SWAP, {1'b0, big_ff} < count_ff, "swap outside the set")

endmodule
